// File: design/rtd_resistance_to_temperature_macros.svh
// assertion macros shared by the rtd resistance-to-temperature rtl
// no dependencies; included by the modules that carry assertions
`ifndef RTD_RESISTANCE_TO_TEMPERATURE_MACROS_SVH
`define RTD_RESISTANCE_TO_TEMPERATURE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RTDR2T_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RTDR2T_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rtdr2t_pkg.sv
// shared types and constants for the rtd resistance-to-temperature block
// no dependencies; used by controller, datapath and top level
package rtdr2t_pkg;

    localparam int SEGMENTS_DEF  = 200;
    localparam int RES_WIDTH_DEF = 32;

    localparam int OFFSET_W    = 15;
    localparam int TEMP_W      = 16;
    localparam int IDX_FIELD_W = 8;
    localparam int FIELD_W     = 32;
    localparam int FRAC_BITS   = 7;   // interpolation fraction is 0..99

    localparam logic [OFFSET_W-1:0]      OFFSET_RESET = 15'd5000;
    localparam logic [6:0]               SCALE        = 7'd100;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 16'sh7fff;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = 16'sh8000;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_CONVERT = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_NEXT
    } addr_sel_t;

    typedef enum logic [1:0] {
        CLAMP_NONE,
        CLAMP_LOW,
        CLAMP_HIGH
    } clamp_t;

    typedef struct packed {
        logic      load_wr;
        logic      capture_r;
        logic      lo_capture;
        logic      scan_step;
        logic      seg_capture;
        clamp_t    clamp;
        logic      mul_load;
        logic      div_step;
        logic      result_load;
        addr_sel_t addr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic r_le_data;
        logic r_lt_data;
    } dp_status_t;

endpackage

// File: design/rtdr2t_dp.sv
// datapath: breakpoint memory, segment scan registers, serial divider, result
// depends on rtdr2t_pkg and rtd_resistance_to_temperature_macros.svh
`include "rtd_resistance_to_temperature_macros.svh"

module rtdr2t_dp #(
    parameter int SEGMENTS  = rtdr2t_pkg::SEGMENTS_DEF,
    parameter int RES_WIDTH = rtdr2t_pkg::RES_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [rtdr2t_pkg::OFFSET_W-1:0]         cfg_wr_data,
    input  logic [rtdr2t_pkg::IDX_FIELD_W-1:0]      entry_index,
    input  logic [rtdr2t_pkg::FIELD_W-1:0]          entry_value,
    input  logic [rtdr2t_pkg::FIELD_W-1:0]          resistance,
    input  rtdr2t_pkg::dp_cmd_t                     cmd,
    output rtdr2t_pkg::dp_status_t                  status,
    output logic signed [rtdr2t_pkg::TEMP_W-1:0]    temperature
);

    localparam int IDX_W   = $clog2(SEGMENTS + 1);
    localparam int NUM_W   = RES_WIDTH + rtdr2t_pkg::FRAC_BITS;
    localparam int KP_W    = IDX_W + 7;
    localparam int SUM_W   = ((KP_W > rtdr2t_pkg::OFFSET_W) ? KP_W : rtdr2t_pkg::OFFSET_W) + 2;
    localparam int FB      = rtdr2t_pkg::FRAC_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEGMENTS);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(rtdr2t_pkg::TEMP_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(rtdr2t_pkg::TEMP_MIN);

    logic [RES_WIDTH-1:0] mem [0:SEGMENTS];

    logic [rtdr2t_pkg::OFFSET_W-1:0] offset_reg;
    logic [RES_WIDTH-1:0]            rdata_reg;
    logic [RES_WIDTH-1:0]            r_reg;
    logic [RES_WIDTH-1:0]            lo_reg;
    logic [RES_WIDTH-1:0]            diff_reg;
    logic [RES_WIDTH-1:0]            den_reg;
    logic [IDX_W-1:0]                scan_idx_reg;
    logic [IDX_W-1:0]                k_reg;
    logic [NUM_W-1:0]                rem_reg;
    logic [NUM_W-1:0]                den_sh_reg;
    logic [FB-1:0]                   q_reg;
    logic signed [rtdr2t_pkg::TEMP_W-1:0] temp_reg;

    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        scan_next;
    logic                    wr_ok;
    logic [KP_W-1:0]         kp;
    logic signed [SUM_W-1:0] sum;
    logic signed [rtdr2t_pkg::TEMP_W-1:0] sat;

    assign wr_ok     = 32'(entry_index) <= 32'(SEGMENTS);
    // hold at the last entry; a hit there is certain, so the extra read is unused
    assign scan_next = (scan_idx_reg == LAST_IDX) ? scan_idx_reg : IDX_W'(scan_idx_reg + 1'b1);

    always_comb begin
        unique case (cmd.addr_sel)
            rtdr2t_pkg::ADDR_FIRST: rd_addr = '0;
            rtdr2t_pkg::ADDR_LAST:  rd_addr = LAST_IDX;
            rtdr2t_pkg::ADDR_NEXT:  rd_addr = scan_next;
            default:                rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && wr_ok) begin
            mem[IDX_W'(entry_index)] <= RES_WIDTH'(entry_value);
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= rtdr2t_pkg::OFFSET_RESET;
        end else if (cfg_wr_en) begin
            offset_reg <= cfg_wr_data;
        end
    end

    assign status.r_le_data = r_reg <= rdata_reg;
    assign status.r_lt_data = r_reg < rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture_r) begin
            r_reg        <= RES_WIDTH'(resistance);
            scan_idx_reg <= '0;
        end
        if (cmd.scan_step) begin
            scan_idx_reg <= scan_next;
        end
        if (cmd.lo_capture) begin
            lo_reg <= rdata_reg;
        end
        if (cmd.seg_capture) begin
            diff_reg <= r_reg - lo_reg;
            den_reg  <= rdata_reg - lo_reg;
            k_reg    <= IDX_W'(scan_idx_reg - 1'b1);
        end
        unique case (cmd.clamp)
            rtdr2t_pkg::CLAMP_LOW: begin
                k_reg <= '0;
                q_reg <= '0;
            end
            rtdr2t_pkg::CLAMP_HIGH: begin
                k_reg <= LAST_IDX;
                q_reg <= '0;
            end
            default: ;
        endcase
        if (cmd.mul_load) begin
            rem_reg    <= NUM_W'(diff_reg) * NUM_W'(rtdr2t_pkg::SCALE);
            den_sh_reg <= NUM_W'(den_reg) << (FB - 1);
            q_reg      <= '0;
        end
        // restoring division, one quotient bit per step, msb first
        if (cmd.div_step) begin
            if (rem_reg >= den_sh_reg) begin
                rem_reg <= rem_reg - den_sh_reg;
                q_reg   <= {q_reg[FB-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[FB-2:0], 1'b0};
            end
            den_sh_reg <= den_sh_reg >> 1;
        end
        if (cmd.result_load) begin
            temp_reg <= sat;
        end
    end

    assign kp  = KP_W'(k_reg) * KP_W'(rtdr2t_pkg::SCALE);
    assign sum = $signed(SUM_W'(kp) + SUM_W'(q_reg) - SUM_W'(offset_reg));

    always_comb begin
        priority if (sum > SAT_HI) begin
            sat = rtdr2t_pkg::TEMP_MAX;
        end else if (sum < SAT_LO) begin
            sat = rtdr2t_pkg::TEMP_MIN;
        end else begin
            sat = rtdr2t_pkg::TEMP_W'(sum);
        end
    end

    assign temperature = temp_reg;

    `RTDR2T_ASSERT_SAME(a_seg_lower_bound, aclk, aresetn, cmd.seg_capture, r_reg >= lo_reg,
        "segment lower breakpoint above the reading")
    `RTDR2T_ASSERT_SAME(a_low_clamp, aclk, aresetn, cmd.clamp == rtdr2t_pkg::CLAMP_LOW,
        r_reg <= rdata_reg, "low clamp without reading at or below first entry")
    `RTDR2T_ASSERT_SAME(a_div_range, aclk, aresetn, cmd.div_step,
        rem_reg < {den_sh_reg, 1'b0}, "divider remainder out of range")

endmodule

// File: design/rtdr2t_ctrl.sv
// controller state machine: load/convert sequencing, scan, divider steps, output valid
// depends on rtdr2t_pkg and rtd_resistance_to_temperature_macros.svh
`include "rtd_resistance_to_temperature_macros.svh"

module rtdr2t_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  rtdr2t_pkg::action_t     s_action,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  rtdr2t_pkg::dp_status_t  status,
    output rtdr2t_pkg::dp_cmd_t     cmd
);

    localparam int CNT_W = $clog2(rtdr2t_pkg::FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOW,
        ST_HIGH,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        div_cnt_next   = div_cnt_reg;
        cmd            = '0;
        cmd.addr_sel   = rtdr2t_pkg::ADDR_FIRST;
        cmd.clamp      = rtdr2t_pkg::CLAMP_NONE;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_action == rtdr2t_pkg::ACT_CONVERT) begin
                        cmd.capture_r = 1'b1;
                        state_next    = ST_LOW;
                    end else begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            ST_LOW: begin
                cmd.lo_capture = 1'b1;
                cmd.addr_sel   = rtdr2t_pkg::ADDR_LAST;
                if (status.r_le_data) begin
                    cmd.clamp  = rtdr2t_pkg::CLAMP_LOW;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_HIGH;
                end
            end
            ST_HIGH: begin
                if (!status.r_lt_data) begin
                    cmd.clamp  = rtdr2t_pkg::CLAMP_HIGH;
                    state_next = ST_FIN;
                end else begin
                    cmd.scan_step = 1'b1;
                    cmd.addr_sel  = rtdr2t_pkg::ADDR_NEXT;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // first upper breakpoint above the reading closes the segment
                if (status.r_lt_data) begin
                    cmd.seg_capture = 1'b1;
                    state_next      = ST_MUL;
                end else begin
                    cmd.lo_capture = 1'b1;
                    cmd.scan_step  = 1'b1;
                    cmd.addr_sel   = rtdr2t_pkg::ADDR_NEXT;
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                div_cnt_next = CNT_W'(rtdr2t_pkg::FRAC_BITS - 1);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.result_load = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `RTDR2T_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.result_load,
        !out_valid_reg || m_tready, "result overwrites an untaken result")
    `RTDR2T_ASSERT_NEXT(a_div_done, aclk, aresetn, state_reg == ST_DIV && div_cnt_reg == '0,
        state_reg == ST_FIN, "divider did not finish after its last step")
    `RTDR2T_ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.result_load,
        m_tvalid && state_reg == ST_IDLE, "result not presented after load")

endmodule

// File: design/rtd_resistance_to_temperature.sv
// rtd resistance to temperature converter, piecewise-linear over a loaded table
// depends on rtdr2t_pkg, rtdr2t_ctrl and rtdr2t_dp
//
// Usage: requests enter on the s_ channel. s_tuser selects the kind: a load
// request writes s_tdata's entry_value into breakpoint entry_index (indexes
// above SEGMENTS are dropped) and gives no result; a convert request returns
// one temperature in hundredths of a degree on the m_ channel. The table holds
// ascending breakpoints, one per degree, and must be written before use.
// cfg_wr_en/cfg_wr_data set the offset subtracted from every result.
// A convert raises m_tvalid once its result is loaded; readings at or past the
// low or high table end skip the scan and the divider. Otherwise the wait is set
// by the linear scan through the single-port breakpoint memory, one entry per
// cycle, followed by a 7-step serial divider for the interpolation fraction.
// One convert is in flight at a time: s_tready is high only between them, so
// the next request is taken only after the previous convert is through.
// Reset (aresetn low, synchronous) returns the controller to idle, drops any
// pending result and restores the offset to 50.00 degrees; the table is kept.
// A stalled receiver holds the result in the output register; the next convert
// is accepted meanwhile and waits at its end until that register is taken.

module rtd_resistance_to_temperature #(
    parameter int SEGMENTS  = rtdr2t_pkg::SEGMENTS_DEF,
    parameter int RES_WIDTH = rtdr2t_pkg::RES_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rtdr2t_pkg::OFFSET_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [71:0]                       s_tdata,   // entry_index, entry_value, resistance
    input  logic [0:0]                        s_tuser,   // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata    // temperature
);

    rtdr2t_pkg::dp_cmd_t    cmd;
    rtdr2t_pkg::dp_status_t status;
    logic signed [rtdr2t_pkg::TEMP_W-1:0] temperature;

    rtdr2t_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (rtdr2t_pkg::action_t'(s_tuser[0])),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtdr2t_dp #(
        .SEGMENTS  (SEGMENTS),
        .RES_WIDTH (RES_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .entry_index (s_tdata[7:0]),
        .entry_value (s_tdata[39:8]),
        .resistance  (s_tdata[71:40]),
        .cmd         (cmd),
        .status      (status),
        .temperature (temperature)
    );

    assign m_tdata = temperature;

endmodule
